FILE: sv/tcw_pkg.sv
// types, codes and constants shared by the text console character writer
// no dependencies
`default_nettype none

package tcw_pkg;

   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_RETURN    = 8'd13;

   localparam logic [15:0] BLANK_CELL = 16'h0720;
   localparam logic [7:0]  TEXT_ATTR  = 8'h07;

   localparam int POS_WIDTH = 11;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] char_code;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } tcw_req_type;

   typedef struct packed {
      logic [POS_WIDTH-1:0] cursor_position;
      logic [15:0]          cell_value;
      logic                 scrolled;
   } tcw_rsp_type;

   typedef enum logic [2:0] {
      ST_BOOT,
      ST_BOOT_SWEEP,
      ST_BOOT_DRAIN,
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP,
      ST_DRAIN,
      ST_DONE
   } tcw_state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic boot_start;
      logic sweep;
      logic load_rsp;
   } tcw_cmd_type;

   typedef struct packed {
      logic go_sweep;
      logic sweep_last;
      logic rsp_busy;
   } tcw_sts_type;

endpackage

`default_nettype wire

FILE: sv/tcw_ctrl.sv
// controller state machine of the text console character writer
// depends on tcw_pkg
`default_nettype none

module tcw_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire tcw_pkg::tcw_sts_type sts,
   output tcw_pkg::tcw_cmd_type      cmd
);

   tcw_pkg::tcw_state_type state_ff;
   tcw_pkg::tcw_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcw_pkg::ST_BOOT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcw_pkg::ST_BOOT: begin
            state_in = tcw_pkg::ST_BOOT_SWEEP;
         end
         tcw_pkg::ST_BOOT_SWEEP: begin
            if (sts.sweep_last) state_in = tcw_pkg::ST_BOOT_DRAIN;
         end
         tcw_pkg::ST_BOOT_DRAIN: begin
            state_in = tcw_pkg::ST_IDLE;
         end
         tcw_pkg::ST_IDLE: begin
            if (req_valid) state_in = tcw_pkg::ST_EXEC;
         end
         tcw_pkg::ST_EXEC: begin
            state_in = sts.go_sweep ? tcw_pkg::ST_SWEEP : tcw_pkg::ST_DONE;
         end
         tcw_pkg::ST_SWEEP: begin
            if (sts.sweep_last) state_in = tcw_pkg::ST_DRAIN;
         end
         tcw_pkg::ST_DRAIN: begin
            state_in = tcw_pkg::ST_DONE;
         end
         tcw_pkg::ST_DONE: begin
            if (!sts.rsp_busy) state_in = tcw_pkg::ST_IDLE;
         end
         default: begin
            state_in = tcw_pkg::ST_BOOT;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         tcw_pkg::ST_BOOT: begin
            cmd.boot_start = 1'b1;
         end
         tcw_pkg::ST_BOOT_SWEEP, tcw_pkg::ST_SWEEP: begin
            cmd.sweep = 1'b1;
         end
         tcw_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         tcw_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         tcw_pkg::ST_DONE: begin
            cmd.load_rsp = !sts.rsp_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: sv/tcw_datapath.sv
// datapath of the text console character writer: screen memory, cursor,
// sweep counter and result register; depends on tcw_pkg
`default_nettype none

module tcw_datapath #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tcw_pkg::tcw_req_type req_data,
   input  wire tcw_pkg::tcw_cmd_type cmd,
   output tcw_pkg::tcw_sts_type      sts,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output tcw_pkg::tcw_rsp_type      rsp_data
);

   localparam int CELLS     = ROWS * COLUMNS;
   localparam int AW        = $clog2(CELLS);
   localparam int CW        = $clog2(COLUMNS);
   localparam int RW        = $clog2(ROWS);
   localparam int LAST_BASE = (ROWS - 1) * COLUMNS;
   localparam int PW        = (AW > tcw_pkg::POS_WIDTH) ? AW : tcw_pkg::POS_WIDTH;

   logic [15:0] mem_q [CELLS];

   tcw_pkg::tcw_req_type req_ff;
   tcw_pkg::tcw_rsp_type rsp_ff;
   logic                 rsp_valid_ff;
   logic [CW-1:0]        col_ff;
   logic [RW-1:0]        row_ff;
   logic [AW-1:0]        addr_ff;
   logic                 copy_ff;
   logic                 cp_valid_ff;
   logic [AW-1:0]        cp_addr_ff;
   logic                 cp_blank_ff;
   logic [15:0]          rd_data_ff;
   logic                 rd_ok_ff;
   logic                 scrolled_ff;

   logic [CW-1:0] col_in;
   logic [RW:0]   row_in;
   logic [CW-1:0] put_col;
   logic          put_we;
   logic [15:0]   put_data;
   logic          wrap;
   logic          rd_ok;
   logic          copy_rd;
   logic [AW:0]   src_sum;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [15:0]   mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   logic [PW-1:0] pos_w;

   function automatic logic [AW-1:0] cell_idx(input logic [RW-1:0] r, input logic [CW-1:0] c);
      return AW'(r) * AW'(COLUMNS) + AW'(c);
   endfunction

   // teletype cursor rules
   always_comb begin
      col_in   = col_ff;
      row_in   = (RW+1)'(row_ff);
      put_col  = col_ff;
      put_we   = 1'b0;
      put_data = tcw_pkg::BLANK_CELL;
      case (req_ff.char_code)
         tcw_pkg::CH_NEWLINE: begin
            col_in = '0;
            row_in = (RW+1)'(row_ff) + (RW+1)'(1);
         end
         tcw_pkg::CH_RETURN: begin
            col_in = '0;
         end
         tcw_pkg::CH_BACKSPACE: begin
            if (col_ff != '0) col_in = col_ff - CW'(1);
            put_col = col_in;
            put_we  = 1'b1;
         end
         default: begin
            put_we   = 1'b1;
            put_data = {tcw_pkg::TEXT_ATTR, req_ff.char_code};
            if (col_ff == CW'(COLUMNS - 1)) begin
               col_in = '0;
               row_in = (RW+1)'(row_ff) + (RW+1)'(1);
            end else begin
               col_in = col_ff + CW'(1);
            end
         end
      endcase
   end

   assign wrap    = (row_in == (RW+1)'(ROWS));
   assign rd_ok   = (int'(req_ff.read_row) < ROWS) && (int'(req_ff.read_col) < COLUMNS);
   assign copy_rd = copy_ff && (addr_ff < AW'(LAST_BASE));
   assign src_sum = (AW+1)'(addr_ff) + (AW+1)'(COLUMNS);

   assign sts.go_sweep   = (req_ff.opcode == tcw_pkg::OP_CLEAR)
                        || ((req_ff.opcode == tcw_pkg::OP_PUT) && wrap);
   assign sts.sweep_last = (addr_ff == AW'(CELLS - 1));
   assign sts.rsp_busy   = rsp_valid_ff && !rsp_ready;

   // single write port, single read port
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cp_addr_ff;
      mem_wdata = cp_blank_ff ? tcw_pkg::BLANK_CELL : rd_data_ff;
      if (cmd.exec && (req_ff.opcode == tcw_pkg::OP_PUT) && put_we) begin
         mem_we    = 1'b1;
         mem_waddr = cell_idx(row_ff, put_col);
         mem_wdata = put_data;
      end else if (cp_valid_ff) begin
         mem_we = 1'b1;
      end
   end

   always_comb begin
      mem_re    = 1'b0;
      mem_raddr = src_sum[AW-1:0];
      if (cmd.exec && (req_ff.opcode == tcw_pkg::OP_READ) && rd_ok) begin
         mem_re    = 1'b1;
         mem_raddr = cell_idx(RW'(req_ff.read_row), CW'(req_ff.read_col));
      end else if (cmd.sweep && copy_rd) begin
         mem_re = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem_q[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= mem_q[mem_raddr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         cp_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cp_valid_ff <= cmd.sweep;
         if (cmd.exec) begin
            case (req_ff.opcode)
               tcw_pkg::OP_PUT: begin
                  col_ff <= col_in;
                  row_ff <= wrap ? RW'(ROWS - 1) : row_in[RW-1:0];
               end
               tcw_pkg::OP_CLEAR: begin
                  col_ff <= '0;
                  row_ff <= '0;
               end
               default: begin
                  col_ff <= col_ff;
               end
            endcase
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // item, sweep and result registers
   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      if (cmd.boot_start) begin
         addr_ff <= '0;
         copy_ff <= 1'b0;
      end
      if (cmd.exec) begin
         addr_ff     <= '0;
         copy_ff     <= (req_ff.opcode == tcw_pkg::OP_PUT);
         rd_ok_ff    <= rd_ok;
         scrolled_ff <= (req_ff.opcode == tcw_pkg::OP_PUT) && wrap;
      end
      if (cmd.sweep) begin
         cp_addr_ff  <= addr_ff;
         cp_blank_ff <= !copy_rd;
         addr_ff     <= addr_ff + AW'(1);
      end
      if (cmd.load_rsp) begin
         rsp_ff.cursor_position <= pos_w[tcw_pkg::POS_WIDTH-1:0];
         rsp_ff.cell_value      <= ((req_ff.opcode == tcw_pkg::OP_READ) && rd_ok_ff)
                                   ? rd_data_ff : 16'h0000;
         rsp_ff.scrolled        <= scrolled_ff;
      end
   end

   assign pos_w     = PW'(row_ff) * PW'(COLUMNS) + PW'(col_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

FILE: sv/text_console_char_writer.sv
// text console character writer: put, read and clear items on a text screen
// put, read and unused codes: after an item is accepted the controller passes EXEC and DONE;
// a put that scrolls and a clear also pass SWEEP (one memory write a cycle) and DRAIN before DONE;
// DONE loads the result register once a waiting result is taken, and only then is a new item accepted
// reset: cursor homes, then a clearing pass (BOOT, BOOT_SWEEP, BOOT_DRAIN) blanks the screen
// depends on tcw_pkg, tcw_ctrl, tcw_datapath
`default_nettype none

module text_console_char_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire tcw_pkg::tcw_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output tcw_pkg::tcw_rsp_type      rsp_data
);

   tcw_pkg::tcw_cmd_type cmd;
   tcw_pkg::tcw_sts_type sts;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   ap_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid && !rsp_ready))
      else $error("result loaded over a waiting item");

   ap_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> cmd.exec)
      else $error("accepted item not executed");

   ap_no_overlap: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep |-> (!cmd.exec && !req_ready))
      else $error("sweep overlaps item work");

endmodule

`default_nettype wire

FILE: tb/text_console_char_writer_test.sv
// testbench for text_console_char_writer: directed table then random put, read, clear and unused-code items
// self-checking against table values and a local screen and cursor predictor; needs tcw_pkg and the block's rtl
`timescale 1ns / 100ps

module text_console_char_writer_test;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int POS_W      = tcw_pkg::POS_WIDTH;
   localparam int RANDOM_ITEMS = 1000;
   localparam int CALM_FIRST   = 300;
   localparam int CALM_LAST    = 549;
   localparam int DRAIN_AT     = 700;
   localparam longint LIMIT    = 12_000_000;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      tcw_pkg::tcw_req_type req;
      int                   reps;
      bit                   typed;
      tcw_pkg::tcw_rsp_type want;
   } step_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   tcw_pkg::tcw_req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   tcw_pkg::tcw_rsp_type rsp_data;

   logic [15:0] screen_model [0:CELL_COUNT-1];
   int unsigned cur_col;
   int unsigned cur_row;

   tcw_pkg::tcw_rsp_type expected_rsp [$];
   step_row_type         directed_steps [$];
   tcw_pkg::tcw_rsp_type oldest;

   bit     calm;
   int     errors;
   int     results_seen;
   int     n_puts, n_reads, n_clears, n_scrolls, n_unused;
   longint cycles;

   text_console_char_writer #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic flag_error(string msg);
      errors++;
      $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   task automatic check_field(string name, int got, int want);
      if (got != want)
         flag_error($sformatf("result %0d %s: got 0x%0h want 0x%0h",
                              results_seen, name, got, want));
   endtask

   function automatic void blank_screen();
      for (int i = 0; i < CELL_COUNT; i++)
         screen_model[i] = tcw_pkg::BLANK_CELL;
   endfunction

   function automatic tcw_pkg::tcw_rsp_type console_step(tcw_pkg::tcw_req_type item);
      tcw_pkg::tcw_rsp_type rsp;
      int unsigned idx;
      rsp = '0;
      case (item.opcode)
         tcw_pkg::OP_PUT: begin
            n_puts++;
            if (item.char_code == tcw_pkg::CH_NEWLINE) begin
               cur_col = 0;
               cur_row++;
            end else if (item.char_code == tcw_pkg::CH_RETURN) begin
               cur_col = 0;
            end else if (item.char_code == tcw_pkg::CH_BACKSPACE) begin
               if (cur_col != 0)
                  cur_col--;
               screen_model[cur_row * COLUMNS + cur_col] = tcw_pkg::BLANK_CELL;
            end else begin
               screen_model[cur_row * COLUMNS + cur_col] = {tcw_pkg::TEXT_ATTR, item.char_code};
               cur_col++;
               if (cur_col >= COLUMNS) begin
                  cur_col = 0;
                  cur_row++;
               end
            end
            if (cur_row >= ROWS) begin
               for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
                  screen_model[i] = screen_model[i + COLUMNS];
               for (int i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++)
                  screen_model[i] = tcw_pkg::BLANK_CELL;
               cur_row = ROWS - 1;
               rsp.scrolled = 1'b1;
               n_scrolls++;
            end
         end
         tcw_pkg::OP_READ: begin
            n_reads++;
            if (item.read_row < ROWS && item.read_col < COLUMNS) begin
               idx = item.read_row * COLUMNS + item.read_col;
               rsp.cell_value = screen_model[idx];
            end
         end
         tcw_pkg::OP_CLEAR: begin
            n_clears++;
            blank_screen();
            cur_col = 0;
            cur_row = 0;
         end
         default: n_unused++;
      endcase
      rsp.cursor_position = POS_W'(cur_row * COLUMNS + cur_col);
      return rsp;
   endfunction

   function automatic void add_step(logic [1:0] op, logic [7:0] ch, int r, int c,
                                    int reps = 1, bit typed = 0, int pos = 0,
                                    int cell_val = 0, bit scr = 0);
      step_row_type s;
      s.req.opcode    = op;
      s.req.char_code = ch;
      s.req.read_row  = 5'(r);
      s.req.read_col  = 7'(c);
      s.reps  = reps;
      s.typed = typed;
      s.want.cursor_position = POS_W'(pos);
      s.want.cell_value      = 16'(cell_val);
      s.want.scrolled        = scr;
      directed_steps.push_back(s);
   endfunction

   function automatic tcw_pkg::tcw_req_type random_item();
      tcw_pkg::tcw_req_type item;
      int pick;
      item.opcode    = tcw_pkg::OP_PUT;
      item.char_code = 8'($urandom_range(0, 255));
      item.read_row  = 5'($urandom);
      item.read_col  = 7'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 48) begin
      end else if (pick < 54) begin
         item.char_code = tcw_pkg::CH_NEWLINE;
      end else if (pick < 57) begin
         item.char_code = tcw_pkg::CH_RETURN;
      end else if (pick < 62) begin
         item.char_code = tcw_pkg::CH_BACKSPACE;
      end else if (pick < 87) begin
         item.opcode   = tcw_pkg::OP_READ;
         item.read_row = 5'(pick < 75 ? cur_row : $urandom_range(0, ROWS - 1));
         item.read_col = 7'($urandom_range(0, COLUMNS - 1));
      end else if (pick < 92) begin
         item.opcode = tcw_pkg::OP_READ;
      end else if (pick < 97) begin
         item.opcode = OP_UNUSED;
      end else if (pick < 98) begin
         item.opcode = tcw_pkg::OP_CLEAR;
      end
      return item;
   endfunction

   task automatic send_item(tcw_pkg::tcw_req_type item, bit typed,
                            tcw_pkg::tcw_rsp_type want);
      tcw_pkg::tcw_rsp_type predicted;
      int gap;
      gap = (!calm && $urandom_range(0, 99) < 28) ? $urandom_range(1, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      predicted = console_step(item);
      expected_rsp.push_back(typed ? want : predicted);
   endtask

   always @(posedge clock) begin
      rsp_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 28);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            flag_error($sformatf("result with nothing expected: %p", rsp_data));
         end else begin
            oldest = expected_rsp.pop_front();
            check_field("cursor_position", rsp_data.cursor_position, oldest.cursor_position);
            check_field("cell_value", rsp_data.cell_value, oldest.cell_value);
            check_field("scrolled", rsp_data.scrolled, oldest.scrolled);
         end
         results_seen++;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycles, expected_rsp.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      tcw_pkg::tcw_rsp_type none;
      none      = '0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      rsp_ready <= 1'b0;
      calm      <= 1'b0;
      blank_screen();
      cur_col = 0;
      cur_row = 0;

      add_step(tcw_pkg::OP_READ, 8'h00, 0, 0, 1, 1, 0, 16'h0720);
      add_step(tcw_pkg::OP_READ, 8'hff, 24, 79, 1, 1, 0, 16'h0720);
      add_step(tcw_pkg::OP_READ, 8'h00, 31, 127, 1, 1, 0, 0);
      add_step(tcw_pkg::OP_READ, 8'h00, 25, 0, 1, 1, 0, 0);
      add_step(tcw_pkg::OP_READ, 8'h00, 0, 80, 1, 1, 0, 0);
      add_step(OP_UNUSED, 8'hff, 31, 127, 1, 1, 0, 0);
      add_step(tcw_pkg::OP_PUT, 8'h41, 0, 0, 1, 1, 1);
      add_step(tcw_pkg::OP_PUT, 8'hff, 31, 127, 1, 1, 2);
      add_step(tcw_pkg::OP_PUT, 8'h00, 0, 0, 1, 1, 3);
      add_step(tcw_pkg::OP_READ, 8'h00, 0, 0, 1, 1, 3, 16'h0741);
      add_step(tcw_pkg::OP_READ, 8'h00, 0, 1, 1, 1, 3, 16'h07ff);
      add_step(tcw_pkg::OP_READ, 8'h00, 0, 2, 1, 1, 3, 16'h0700);
      add_step(tcw_pkg::OP_PUT, tcw_pkg::CH_BACKSPACE, 0, 0, 1, 1, 2);
      add_step(tcw_pkg::OP_READ, 8'h00, 0, 2, 1, 1, 2, 16'h0720);
      add_step(tcw_pkg::OP_PUT, tcw_pkg::CH_RETURN, 0, 0, 1, 1, 0);
      // backspace at the first column still blanks the cell
      add_step(tcw_pkg::OP_PUT, tcw_pkg::CH_BACKSPACE, 0, 0, 1, 1, 0);
      add_step(tcw_pkg::OP_READ, 8'h00, 0, 0, 1, 1, 0, 16'h0720);
      add_step(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE, 0, 0, 1, 1, 80);
      // a full row, last one wraps
      add_step(tcw_pkg::OP_PUT, 8'h77, 0, 0, COLUMNS);
      add_step(tcw_pkg::OP_READ, 8'h00, 1, 79, 1, 1, 160, 16'h0777);
      add_step(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE, 0, 0, ROWS - 3);
      add_step(tcw_pkg::OP_PUT, 8'h7a, 0, 0, 1, 1, 1921);
      add_step(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE, 0, 0, 1, 1, 1920, 0, 1);
      add_step(tcw_pkg::OP_READ, 8'h00, 23, 0, 1, 1, 1920, 16'h077a);
      add_step(tcw_pkg::OP_READ, 8'h00, 24, 0, 1, 1, 1920, 16'h0720);
      // wrap on the last row scrolls
      add_step(tcw_pkg::OP_PUT, 8'h71, 0, 0, COLUMNS);
      add_step(tcw_pkg::OP_PUT, tcw_pkg::CH_BACKSPACE, 0, 0);
      add_step(tcw_pkg::OP_CLEAR, 8'h00, 0, 0, 1, 1, 0);
      add_step(tcw_pkg::OP_READ, 8'h00, 23, 0, 1, 1, 0, 16'h0720);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i])
         for (int k = 0; k < directed_steps[i].reps; k++)
            send_item(directed_steps[i].req, directed_steps[i].typed, directed_steps[i].want);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == CALM_FIRST)
            calm <= 1'b1;
         if (i == CALM_LAST + 1)
            calm <= 1'b0;
         if (i == DRAIN_AT) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (expected_rsp.size() != 0);
         end
         send_item(random_item(), 1'b0, none);
      end
      req_valid <= 1'b0;

      while (expected_rsp.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("covered %0d results: %0d puts, %0d reads, %0d clears, %0d unused codes",
               results_seen, n_puts, n_reads, n_clears, n_unused);
      $display("screen scrolled %0d times in %0d cycles", n_scrolls, cycles);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
